@@ design/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: forward retry tracker shared definitions
// Table size, field widths, register and command codes, chain word types.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ADDR_W   = 64;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] RETRY_DELAY_RST = TIME_W'(1000);
  localparam logic [CNT_W-1:0]  MAX_RETRIES_RST = CNT_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_RETRY_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = CFG_IDX_W'(1);

  localparam logic CMD_ATTEMPT = 1'b0;
  localparam logic CMD_REMOVE  = 1'b1;

  // word walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [TIME_W-1:0] now;
    logic              hit;
    logic              fwd;
    logic              drop;
    logic              tracked;
    logic              free_seen;
    logic [IDX_W-1:0]  free_idx;
  } token_t;

  // new-entry write broadcast to all cells
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [TIME_W-1:0] now;
  } ins_t;

  typedef struct packed {
    logic forward_now;
    logic drop_stored;
    logic is_tracked;
  } res_t;

endpackage

@@ design/frt_req_if.sv @@
// ----------------------------------------------------------------------------
// frt_req_if: command channel
// Valid/ready channel carrying one attempt or remove command word.
// ----------------------------------------------------------------------------
interface frt_req_if import frt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] dest_addr_high;
  logic [ADDR_W-1:0] dest_addr_low;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, command, dest_addr_high, dest_addr_low, now_time,
                  input ready);
  modport sink   (input valid, command, dest_addr_high, dest_addr_low, now_time,
                  output ready);
endinterface

@@ design/frt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// frt_rsp_if: result channel
// Valid/ready channel carrying one result word per command.
// ----------------------------------------------------------------------------
interface frt_rsp_if import frt_pkg::*; ();
  logic valid;
  logic ready;
  logic forward_now;
  logic drop_stored;
  logic is_tracked;

  modport source (output valid, forward_now, drop_stored, is_tracked, input ready);
  modport sink   (input valid, forward_now, drop_stored, is_tracked, output ready);
endinterface

@@ design/frt_cell.sv @@
// ----------------------------------------------------------------------------
// frt_cell: one table slot
// Holds one entry, checks the passing word against it and hands it on.
// ----------------------------------------------------------------------------
module frt_cell import frt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [TIME_W-1:0] retry_delay_i,
  input  logic [CNT_W-1:0]  max_retries_i,
  input  ins_t              ins_i,
  input  token_t            tok_i,
  output token_t            tok_o
);

  logic              vld_q, vld_d;
  logic [ADDR_W-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              tvld_q;
  token_t            tok_q, tok_d;

  logic              match;
  logic [TIME_W-1:0] elapsed;

  assign match   = tok_i.valid && vld_q && (hi_q == tok_i.addr_hi) && (lo_q == tok_i.addr_lo);
  assign elapsed = tok_i.now - time_q;

  always_comb begin
    vld_d  = vld_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    time_d = time_q;
    cnt_d  = cnt_q;
    tok_d  = tok_i;
    if (match) begin
      tok_d.hit     = 1'b1;
      tok_d.fwd     = 1'b0;
      tok_d.drop    = 1'b0;
      tok_d.tracked = 1'b0;
      if (tok_i.cmd == CMD_REMOVE) begin
        vld_d = 1'b0;
      end else if (elapsed >= retry_delay_i) begin
        if (cnt_q >= max_retries_i) begin
          vld_d        = 1'b0;
          tok_d.drop   = 1'b1;
        end else begin
          time_d        = tok_i.now;
          cnt_d         = cnt_q + CNT_W'(1);
          tok_d.fwd     = 1'b1;
          tok_d.tracked = 1'b1;
        end
      end else begin
        tok_d.tracked = 1'b1;
      end
    end else if (tok_i.valid && !vld_q && !tok_i.free_seen) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = cell_idx_i;
    end
    // new entry claimed at the end of a missed lookup
    if (ins_i.valid && (ins_i.idx == cell_idx_i)) begin
      vld_d  = 1'b1;
      hi_d   = ins_i.addr_hi;
      lo_d   = ins_i.addr_lo;
      time_d = ins_i.now;
      cnt_d  = CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      tvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      tvld_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    time_q <= time_d;
    cnt_q  <= cnt_d;
    tok_q  <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tvld_q;
  end

endmodule

@@ design/frt_out_buf.sv @@
// ----------------------------------------------------------------------------
// frt_out_buf: result output register with skid slot
// Keeps finished results while the result channel stalls.
// ----------------------------------------------------------------------------
module frt_out_buf import frt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  res_t          data_i,
  output logic          full_o,
  frt_rsp_if.source     rsp
);

  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  res_t out_q, out_d, skid_q, skid_d;
  logic pop;

  assign pop = out_vld_q && rsp.ready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = push_i;
        skid_d     = data_i;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o          = skid_vld_q;
  assign rsp.valid       = out_vld_q;
  assign rsp.forward_now = out_q.forward_now;
  assign rsp.drop_stored = out_q.drop_stored;
  assign rsp.is_tracked  = out_q.is_tracked;

endmodule

@@ design/forward_retry_tracker.sv @@
// ----------------------------------------------------------------------------
// forward_retry_tracker: per-destination forwarding retry tracker
// Table of destination entries kept in a row of cells; a lookup word walks
// the row one cell per cycle, and a missed attempt claims the lowest free slot.
// ----------------------------------------------------------------------------
// The lookup walks the cell row one slot per cycle; the finished word is then
//   registered in the output buffer, which drives the result channel.
// One lookup in the row at a time: the next command waits until the previous
//   lookup has left the last cell. A stalled result is held in an output
//   register and a skid slot; the next command is taken while one result waits.
// Reset: all slots invalid, retry_delay = 1000, max_retries = 3. No clear pass.
module forward_retry_tracker import frt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  frt_req_if.sink               req,
  frt_rsp_if.source             rsp
);

  // config registers
  logic [TIME_W-1:0] retry_delay_q;
  logic [CNT_W-1:0]  max_retries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_delay_q <= RETRY_DELAY_RST;
      max_retries_q <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RETRY_DELAY: retry_delay_q <= cfg_data_i[TIME_W-1:0];
        REG_MAX_RETRIES: max_retries_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // chain of cells: tok[i] feeds cell i, tok[TABLE_ENTRIES] is the finished word
  token_t tok [TABLE_ENTRIES+1];
  token_t fin;
  ins_t   ins;
  logic   busy_q, skid_full, accept;
  logic [TABLE_ENTRIES-1:0] tok_vld;

  assign req.ready = !busy_q && !skid_full;
  assign accept    = req.valid && req.ready;

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = accept;
    tok[0].cmd       = req.command;
    tok[0].addr_hi   = req.dest_addr_high;
    tok[0].addr_lo   = req.dest_addr_low;
    tok[0].now       = req.now_time;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    frt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (IDX_W'(g)),
      .retry_delay_i (retry_delay_q),
      .max_retries_i (max_retries_q),
      .ins_i         (ins),
      .tok_i         (tok[g]),
      .tok_o         (tok[g+1])
    );
    assign tok_vld[g] = tok[g+1].valid;
  end

  assign fin = tok[TABLE_ENTRIES];

  // missed attempt: claim the lowest free slot seen along the row
  always_comb begin
    ins.valid   = fin.valid && !fin.hit && (fin.cmd == CMD_ATTEMPT) && fin.free_seen;
    ins.idx     = fin.free_idx;
    ins.addr_hi = fin.addr_hi;
    ins.addr_lo = fin.addr_lo;
    ins.now     = fin.now;
  end

  res_t res;
  always_comb begin
    if (fin.hit) begin
      res.forward_now = fin.fwd;
      res.drop_stored = fin.drop;
      res.is_tracked  = fin.tracked;
    end else if (fin.cmd == CMD_ATTEMPT) begin
      // missed attempt forwards; tracked if a free slot was seen, untracked when the table is full
      res.forward_now = 1'b1;
      res.drop_stored = 1'b0;
      res.is_tracked  = fin.free_seen;
    end else begin
      res = '0;
    end
  end

  // one lookup in flight, from accept until it leaves the last cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (fin.valid) begin
      busy_q <= 1'b0;
    end
  end

  frt_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fin.valid),
    .data_i (res),
    .full_o (skid_full),
    .rsp    (rsp)
  );

  // checks
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one lookup in the cell row");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (tok_vld == '0))
    else $error("lookup in the row while not busy");

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.valid |=> !busy_q)
    else $error("busy not released after lookup finished");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> rsp.valid)
    else $error("skid slot filled while output register empty");

  a_fin_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.valid |-> !skid_full)
    else $error("finished result with no room to hold it");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: forward_retry_tracker block test
// Drives attempt and remove commands over the command channel while a local
// copy of the destination table predicts each result word. Covers reset
// values, drops, table-full forwarding, time wrap, register extremes, output
// backpressure and long random traffic with idle gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import frt_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  RESET_CYCLES = 12;
  localparam int  STALL_LIMIT = 4000;   // cycles with no word moving on either side
  localparam int  POOL_SIZE = 20;       // more than the table holds, so it fills up
  localparam int  PHASE_WORDS = 125;
  localparam int  HOLD_CYCLES = 200;    // long receiver hold for the backpressure test
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(2);  // no register here

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frt_req_if req_ch ();
  frt_rsp_if rsp_ch ();

  forward_retry_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // local copy of the destination table and the two registers
  logic              slot_used [TABLE_ENTRIES];
  logic [ADDR_W-1:0] slot_hi   [TABLE_ENTRIES];
  logic [ADDR_W-1:0] slot_lo   [TABLE_ENTRIES];
  logic [TIME_W-1:0] slot_time [TABLE_ENTRIES];
  logic [CNT_W-1:0]  slot_cnt  [TABLE_ENTRIES];
  logic [TIME_W-1:0] delay_reg;
  logic [CNT_W-1:0]  max_reg;

  res_t              expected_q [$];
  logic [127:0]      dest_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_now;

  bit gaps_on;        // sender inserts random idle gaps
  bit stalls_on;      // receiver drops ready at random
  int rsp_hold_req;   // receiver holds ready low this many cycles when nonzero

  int errors;
  int words_sent;
  int words_checked;
  int fwd_cnt, drop_cnt, full_cnt, wait_cnt, remove_cnt;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Table predictor: one call per accepted command word.
  // --------------------------------------------------------------------------
  function automatic res_t track_command(input logic cmd, input logic [ADDR_W-1:0] hi,
                                         input logic [ADDR_W-1:0] lo,
                                         input logic [TIME_W-1:0] now);
    res_t              r;
    int                hit;
    int                free_slot;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_hi[i] == hi && slot_lo[i] == lo) hit = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    if (cmd == CMD_REMOVE) begin
      // remove: a miss leaves the table alone
      if (hit >= 0) slot_used[hit] = 1'b0;
    end else if (hit >= 0) begin
      elapsed = now - slot_time[hit];   // modular time
      if (elapsed >= delay_reg) begin
        if (slot_cnt[hit] >= max_reg) begin
          slot_used[hit] = 1'b0;
          r.drop_stored = 1'b1;
        end else begin
          slot_time[hit] = now;
          slot_cnt[hit] = slot_cnt[hit] + 1'b1;
          r.forward_now = 1'b1;
          r.is_tracked = 1'b1;
        end
      end else begin
        r.is_tracked = 1'b1;            // too early, nothing changes
      end
    end else begin
      r.forward_now = 1'b1;
      if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_hi[free_slot] = hi;
        slot_lo[free_slot] = lo;
        slot_time[free_slot] = now;
        slot_cnt[free_slot] = CNT_W'(1);
        r.is_tracked = 1'b1;
      end
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: drive one word at the falling edge, hold until accepted.
  // valid stays high into the next word when no gap follows.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic cmd, input logic [ADDR_W-1:0] hi,
                          input logic [ADDR_W-1:0] lo, input logic [TIME_W-1:0] now);
    res_t r;
    int   gap;
    @(negedge clk_i);
    req_ch.valid = 1'b1;
    req_ch.command = cmd;
    req_ch.dest_addr_high = hi;
    req_ch.dest_addr_low = lo;
    req_ch.now_time = now;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    r = track_command(cmd, hi, lo, now);
    expected_q.push_back(r);
    words_sent++;
    if (cmd == CMD_REMOVE) remove_cnt++;
    else if (r.drop_stored) drop_cnt++;
    else if (r.forward_now && !r.is_tracked) full_cnt++;
    else if (r.forward_now) fwd_cnt++;
    else wait_cnt++;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // register write while idle; the local copy masks as the block does
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_RETRY_DELAY) delay_reg = data[TIME_W-1:0];
    else if (idx == REG_MAX_RETRIES) max_reg = data[CNT_W-1:0];
  endtask

  task automatic configure(input logic [TIME_W-1:0] dly, input logic [CFG_DATA_W-1:0] maxr);
    settle();
    write_reg(REG_RETRY_DELAY, dly);
    write_reg(REG_MAX_RETRIES, maxr);
  endtask

  // remove every tracked destination so the next phase starts empty
  task automatic flush_table();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i]) send_cmd(CMD_REMOVE, slot_hi[i], slot_lo[i], clock_now);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: delay 1000, max 3. Walks one destination up to the
  // drop, checks the too-early case, removes with and without a match.
  task automatic test_reset_values();
    logic [ADDR_W-1:0] ones;
    ones = '1;
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd0);       // new, count 1
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd999);     // one tick early
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd1000);    // count 2
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd2000);    // count 3
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd3000);    // at max: drop
    send_cmd(CMD_ATTEMPT, ones, ones, 32'd3000);
    send_cmd(CMD_REMOVE, ones, ones, 32'd3000);
    send_cmd(CMD_REMOVE, ones, ones, 32'd3000); // miss
    send_cmd(CMD_ATTEMPT, '0, '0, 32'd3001);    // freed slot, tracked again
    send_cmd(CMD_REMOVE, '0, '0, 32'd3001);
  endtask

  // max_retries 0: new slot starts at count 1, so first due attempt drops it.
  // A write to an unmapped index must not disturb anything.
  task automatic test_zero_max_retries();
    configure(32'd10, 32'd0);
    write_reg(REG_NONE, '1);
    send_cmd(CMD_ATTEMPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd5000);
    send_cmd(CMD_ATTEMPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd5009);
    send_cmd(CMD_ATTEMPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 32'd5010);
  endtask

  // elapsed time across the 32-bit wrap
  task automatic test_time_wrap();
    configure(32'd100, 32'd3);
    send_cmd(CMD_ATTEMPT, 64'h8000_0000_0000_0001, 64'h1, 32'hffff_fff0);
    send_cmd(CMD_ATTEMPT, 64'h8000_0000_0000_0001, 64'h1, 32'h0000_0050);  // 96 ticks
    send_cmd(CMD_ATTEMPT, 64'h8000_0000_0000_0001, 64'h1, 32'h0000_0054);  // 100 ticks
  endtask

  // fill all slots, overflow forwards untracked, a freed slot is reused
  task automatic test_table_full();
    clock_now = 32'd20000;
    flush_table();
    for (int i = 0; i <= TABLE_ENTRIES; i++)
      send_cmd(CMD_ATTEMPT, 64'h1 << i, ~(64'h1 << i), clock_now);
    send_cmd(CMD_REMOVE, 64'h1 << 5, ~(64'h1 << 5), clock_now);
    send_cmd(CMD_ATTEMPT, 64'hdead_beef_0000_0000, 64'h0000_0000_cafe_f00d, clock_now);
    send_cmd(CMD_ATTEMPT, 64'h1 << TABLE_ENTRIES, ~(64'h1 << TABLE_ENTRIES), clock_now);
  endtask

  // receiver holds off while the sender keeps offering back to back words;
  // the block must fill its output stage and stall the command channel
  task automatic test_output_backpressure();
    settle();
    gaps_on = 1'b0;
    rsp_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      clock_now = clock_now + 32'd40;
      send_cmd(CMD_ATTEMPT, {$urandom, $urandom}, {$urandom, $urandom}, clock_now);
    end
  endtask

  // one random traffic phase at a given register setting
  task automatic run_random_phase(input logic [TIME_W-1:0] dly,
                                  input logic [CFG_DATA_W-1:0] maxr,
                                  input bit gaps, input bit stalls);
    int                sel;
    logic [127:0]      dest;
    logic              cmd;
    logic [TIME_W-1:0] step;
    configure(dly, maxr);
    gaps_on = gaps;
    stalls_on = stalls;
    for (int i = 0; i < POOL_SIZE; i++)
      dest_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    flush_table();
    for (int n = 0; n < PHASE_WORDS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) step = $urandom_range(0, (delay_reg >> 2) + 2);
      else if (sel < 8) step = delay_reg;          // exactly due
      else if (sel < 9) step = delay_reg - 1'b1;   // one tick short
      else step = $urandom;                        // big jump, often wraps
      clock_now = clock_now + step;
      cmd = ($urandom_range(0, 99) < 15) ? CMD_REMOVE : CMD_ATTEMPT;
      dest = ($urandom_range(0, 99) < 85) ? dest_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : {$urandom, $urandom, $urandom, $urandom};
      send_cmd(cmd, dest[127:64], dest[63:0], clock_now);
    end
  endtask

  // register extremes and a few in between; upper data bits on max_retries
  // must be ignored
  task automatic test_random_settings();
    clock_now = $urandom;
    run_random_phase(32'd1000, 32'd3, 1'b0, 1'b0);          // no idling at all
    run_random_phase(32'd0, 32'd0, 1'b1, 1'b1);
    run_random_phase(32'hffff_ffff, 32'd255, 1'b1, 1'b1);
    run_random_phase(32'd50, 32'habcd_0002, 1'b1, 1'b0);
    run_random_phase(32'd1, 32'd1, 1'b0, 1'b1);
    run_random_phase($urandom_range(0, 2000), $urandom_range(0, 6), 1'b1, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge
  // --------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (rsp_hold_req) @(negedge clk_i);
        rsp_hold_req = 0;
      end else if (stalls_on && $urandom_range(0, 99) < 3) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(8, 40)) @(negedge clk_i);
      end else begin
        rsp_ch.ready = !stalls_on || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result word with none expected, actual fwd=%0b drop=%0b trk=%0b",
                 $time, rsp_ch.forward_now, rsp_ch.drop_stored, rsp_ch.is_tracked);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("forward_now", exp_r.forward_now, rsp_ch.forward_now);
        check_field("drop_stored", exp_r.drop_stored, rsp_ch.drop_stored);
        check_field("is_tracked", exp_r.is_tracked, rsp_ch.is_tracked);
        words_checked++;
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_ATTEMPT;
    req_ch.dest_addr_high = '0;
    req_ch.dest_addr_low = '0;
    req_ch.now_time = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    rsp_hold_req = 0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    fwd_cnt = 0;
    drop_cnt = 0;
    full_cnt = 0;
    wait_cnt = 0;
    remove_cnt = 0;
    idle_cycles = 0;
    clock_now = '0;
    delay_reg = RETRY_DELAY_RST;
    max_reg = MAX_RETRIES_RST;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_hi[i] = '0;
      slot_lo[i] = '0;
      slot_time[i] = '0;
      slot_cnt[i] = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_zero_max_retries();
    test_time_wrap();
    test_table_full();
    test_output_backpressure();
    test_random_settings();

    settle();
    repeat (TABLE_ENTRIES + 4) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_q.size());
      errors++;
    end
    $display("Covered %0d commands (%0d removes), %0d results checked, %0d mismatches.",
             words_sent, remove_cnt, words_checked, errors);
    $display("Outcomes: %0d forwards, %0d too early, %0d drops, %0d untracked (table full).",
             fwd_cnt, wait_cnt, drop_cnt, full_cnt);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ forward_retry_tracker.f @@
design/frt_pkg.sv
design/frt_req_if.sv
design/frt_rsp_if.sv
design/frt_cell.sv
design/frt_out_buf.sv
design/forward_retry_tracker.sv
verif/testbench.sv
